/* hw/rtl/ced_pkg.sv */
`timescale 1ns / 1ps

package ced_pkg;

    localparam int LINE_COUNT_BITS_DEF = 16;
    localparam int SLOT_COUNT          = 3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_X         = 8'h78;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_END_AFTER_BS = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEX    = 3'd2;
    localparam logic [2:0] STATUS_HEX_RANGE  = 3'd3;
    localparam logic [2:0] STATUS_OCT_RANGE  = 3'd4;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_AFTER_BS = 3'd1,
        MODE_AFTER_X  = 3'd2,
        MODE_HEX      = 3'd3,
        MODE_OCT      = 3'd4,
        MODE_DEAD     = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [8:0] accum;
        logic [2:0] err;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [2:0]  status_code;
        logic [15:0] line_offset;
        logic        run_end;
    } result_t;

endpackage

/* hw/rtl/c_escape_sequence_decoder.sv */
`timescale 1ns / 1ps

// c escape sequence decoder
// s_* carries the escaped text one byte per transaction, s_tlast marks the
// final byte of a text. m_* carries the decoded bytes and, after the final
// byte, one status transaction (m_tuser high) with the error code and the
// newline count. m_tlast is high on the last result caused by an input byte.
// results of a byte are registered and appear on m_* in the cycle after it is accepted.
// one byte per cycle while each byte causes at most one result and m_tready
// is high; a byte that causes two or three results holds s_tready low while
// the three-entry result buffer drains, one per cycle while m_tready is high.
// a byte that causes no result (backslash, digits, dropped bytes after an
// error) leaves the result buffer empty.
// when the receiver stalls, results wait in the buffer and s_tready drops
// once the buffer holds a result that will not leave in this cycle.
// reset clears the parse state, the newline count and the result buffer;
// after the status transaction the parser is back in its reset state.
module c_escape_sequence_decoder #(
    parameter int LINE_COUNT_BITS = ced_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], status_code[10:8], line_offset[26:11]
    output logic        m_tuser,   // is_status
    output logic        m_tlast    // run_end
);
    import ced_pkg::*;

    parse_state_t               state_reg, state_next;
    logic [LINE_COUNT_BITS-1:0] lines_reg, lines_next;
    logic [1:0]                 cnt_reg;
    result_t                    slot_reg [SLOT_COUNT];
    result_t                    step_res [SLOT_COUNT];
    logic [1:0]                 step_count;
    logic                       in_xfer, out_xfer;

    ced_step #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_step (
        .state_cur (state_reg),
        .lines_cur (lines_reg),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .state_nxt (state_next),
        .lines_nxt (lines_next),
        .res_count (step_count),
        .res       (step_res)
    );

    assign m_tvalid = (cnt_reg != 2'd0);
    assign out_xfer = m_tvalid && m_tready;
    // accept when the buffer is empty or its only entry leaves now
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tdata = {5'd0, slot_reg[0].line_offset, slot_reg[0].status_code,
                      slot_reg[0].out_byte};
    assign m_tuser = slot_reg[0].is_status;
    assign m_tlast = slot_reg[0].run_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '{mode: MODE_NORMAL, accum: 9'd0, err: STATUS_OK};
            lines_reg <= '0;
            cnt_reg   <= 2'd0;
        end else if (in_xfer) begin
            state_reg <= state_next;
            lines_reg <= lines_next;
            cnt_reg   <= step_count;
        end else if (out_xfer) begin
            cnt_reg   <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_reg[i] <= step_res[i];
        end else if (out_xfer) begin
            for (int i = 0; i < SLOT_COUNT - 1; i++) slot_reg[i] <= slot_reg[i + 1];
        end
    end

endmodule

/* hw/rtl/ced_step.sv */
`timescale 1ns / 1ps

module ced_step #(
    parameter int LINE_COUNT_BITS = ced_pkg::LINE_COUNT_BITS_DEF
) (
    input  ced_pkg::parse_state_t       state_cur,
    input  logic [LINE_COUNT_BITS-1:0]  lines_cur,
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    output ced_pkg::parse_state_t       state_nxt,
    output logic [LINE_COUNT_BITS-1:0]  lines_nxt,
    output logic [1:0]                  res_count,
    output ced_pkg::result_t            res [ced_pkg::SLOT_COUNT]
);
    import ced_pkg::*;

    localparam int WIDE_BITS = (LINE_COUNT_BITS > 16) ? LINE_COUNT_BITS : 16;
    localparam logic [LINE_COUNT_BITS-1:0] LINES_MAX = '1;

    // {valid, value}
    function automatic logic [4:0] hex_lookup(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        return r;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h74:   r = 8'h09;
            8'h6E:   r = 8'h0A;
            8'h76:   r = 8'h0B;
            8'h66:   r = 8'h0C;
            8'h72:   r = 8'h0D;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic result_t data_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    logic [WIDE_BITS-1:0] lines_wide;
    logic [15:0]          lines_sat;
    logic [4:0]           hex_d;
    logic                 oct_ok;
    logic [11:0]          acc_grown;

    assign hex_d  = hex_lookup(in_byte);
    assign oct_ok = (in_byte >= 8'h30) && (in_byte <= 8'h37);

    always_comb
    begin
        parse_state_t st;
        logic [LINE_COUNT_BITS-1:0] ln;
        logic [1:0] n;
        logic [3:0] dig;
        logic dig_ok;
        logic plain;
        logic [2:0] code;

        st    = state_cur;
        ln    = lines_cur;
        n     = 2'd0;
        plain = 1'b0;
        dig   = 4'd0;
        dig_ok = 1'b0;
        acc_grown = 12'd0;
        lines_wide = '0;
        lines_sat  = 16'd0;
        code  = STATUS_OK;
        for (int i = 0; i < SLOT_COUNT; i++) res[i] = '0;

        case (state_cur.mode)
            MODE_DEAD:
            begin
            end
            MODE_AFTER_BS:
            begin
                if (in_byte == CHAR_X) begin
                    st.mode = MODE_AFTER_X;
                end else if (oct_ok) begin
                    st.accum = {6'd0, in_byte[2:0]};
                    st.mode  = MODE_OCT;
                end else begin
                    if (in_byte == CHAR_NEWLINE && ln != LINES_MAX) ln = ln + 1'b1;
                    res[n] = data_result(simple_escape(in_byte));
                    n = n + 2'd1;
                    st.mode = MODE_NORMAL;
                end
            end
            MODE_AFTER_X:
            begin
                if (hex_d[4]) begin
                    st.accum = {5'd0, hex_d[3:0]};
                    st.mode  = MODE_HEX;
                end else begin
                    st.err  = STATUS_BAD_HEX;
                    st.mode = MODE_DEAD;
                end
            end
            MODE_HEX, MODE_OCT:
            begin
                if (state_cur.mode == MODE_HEX) begin
                    dig_ok = hex_d[4];
                    dig    = hex_d[3:0];
                    acc_grown = {state_cur.accum[7:0], 4'd0} + {8'd0, dig};
                end else begin
                    dig_ok = oct_ok;
                    dig    = {1'b0, in_byte[2:0]};
                    acc_grown = {1'b0, state_cur.accum[7:0], 3'd0} + {8'd0, dig};
                end
                if (dig_ok) begin
                    if (acc_grown >= 12'd256) begin
                        st.accum = 9'd256;
                        st.err   = (state_cur.mode == MODE_HEX) ? STATUS_HEX_RANGE
                                                                : STATUS_OCT_RANGE;
                        st.mode  = MODE_DEAD;
                    end else begin
                        st.accum = acc_grown[8:0];
                    end
                end else begin
                    res[n] = data_result(state_cur.accum[7:0]);
                    n = n + 2'd1;
                    st.accum = 9'd0;
                    st.mode  = MODE_NORMAL;
                    plain    = 1'b1;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            if (in_byte == CHAR_BACKSLASH) begin
                st.mode = MODE_AFTER_BS;
            end else begin
                if (in_byte == CHAR_NEWLINE && ln != LINES_MAX) ln = ln + 1'b1;
                res[n] = data_result(in_byte);
                n = n + 2'd1;
            end
        end

        if (in_last) begin
            case (st.mode)
                MODE_DEAD:     code = st.err;
                MODE_AFTER_BS: code = STATUS_END_AFTER_BS;
                MODE_AFTER_X:  code = STATUS_BAD_HEX;
                default:       code = STATUS_OK;
            endcase
            if (st.mode == MODE_HEX || st.mode == MODE_OCT) begin
                res[n] = data_result(st.accum[7:0]);
                n = n + 2'd1;
            end
            lines_wide = WIDE_BITS'(ln);
            lines_sat  = (lines_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : lines_wide[15:0];
            res[n] = '0;
            res[n].is_status   = 1'b1;
            res[n].status_code = code;
            res[n].line_offset = lines_sat;
            n = n + 2'd1;
            st.mode  = MODE_NORMAL;
            st.accum = 9'd0;
            st.err   = STATUS_OK;
            ln       = '0;
        end

        if (n != 2'd0) res[n - 2'd1].run_end = 1'b1;

        state_nxt = st;
        lines_nxt = ln;
        res_count = n;
    end

endmodule

/* sim/tb_c_escape_sequence_decoder.sv */
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder;
    import ced_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    c_escape_sequence_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb_c_escape_sequence_decoder: errors");
        $finish;
    end

    // predictor state
    mode_t       parse_st  = MODE_NORMAL;
    int unsigned digit_acc = 0;
    logic [2:0]  err_code  = STATUS_OK;
    logic [15:0] lines     = 16'd0;

    result_t     byte_results [$];
    result_t     expected_out [$];
    logic [7:0]  text_buf [$];
    string       esc_set      = "abtnvfr";
    bit          idle_on      = 1'b1;
    int          mismatches   = 0;
    int          results_taken = 0;
    int          long_hold    = 0;

    // directed stimulus, expected results typed in only where obvious
    stim_row_t dir_rows [26] = '{
        '{"A",            1'b0, 1'b1, '{"A", 1'b0, STATUS_OK, 16'd0, 1'b1}},
        '{8'h00,          1'b0, 1'b0, '0},
        '{8'hFF,          1'b0, 1'b0, '0},
        '{CHAR_NEWLINE,   1'b0, 1'b1, '{CHAR_NEWLINE, 1'b0, STATUS_OK, 16'd0, 1'b1}},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{"n",            1'b0, 1'b0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{CHAR_X,         1'b0, 1'b0, '0},
        '{"f",            1'b0, 1'b0, '0},
        '{"F",            1'b0, 1'b0, '0},
        '{"Z",            1'b0, 1'b0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{"3",            1'b0, 1'b0, '0},
        '{"7",            1'b0, 1'b0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{CHAR_NEWLINE,   1'b0, 1'b0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{"1",            1'b1, 1'b0, '0},
        '{CHAR_BACKSLASH, 1'b1, 1'b1, '{8'h00, 1'b1, STATUS_END_AFTER_BS, 16'd0, 1'b1}},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{CHAR_X,         1'b0, 1'b0, '0},
        '{"g",            1'b1, 1'b1, '{8'h00, 1'b1, STATUS_BAD_HEX, 16'd0, 1'b1}},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, '0},
        '{"4",            1'b0, 1'b0, '0},
        '{"0",            1'b0, 1'b0, '0},
        '{"0",            1'b1, 1'b1, '{8'h00, 1'b1, STATUS_OCT_RANGE, 16'd0, 1'b1}}
    };

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic void bump_lines();
        if (lines != 16'hFFFF)
            lines = lines + 16'd1;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        result_t r;
        r = '{b, 1'b0, STATUS_OK, 16'd0, 1'b0};
        byte_results.push_back(r);
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == CHAR_BACKSLASH)
            parse_st = MODE_AFTER_BS;
        else
        begin
            if (b == CHAR_NEWLINE)
                bump_lines();
            emit_byte(b);
        end
    endfunction

    // decoded bytes and status caused by one input byte
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int         hv;
        logic [7:0] esc;
        logic [2:0] code;
        result_t    st;
        byte_results.delete();
        case (parse_st)
            MODE_DEAD: ;
            MODE_AFTER_BS:
            begin
                if (b == CHAR_X)
                    parse_st = MODE_AFTER_X;
                else if (b >= "0" && b <= "7")
                begin
                    digit_acc = int'(b - "0");
                    parse_st  = MODE_OCT;
                end
                else
                begin
                    if (b == CHAR_NEWLINE)
                        bump_lines();
                    case (b)
                        "a":     esc = 8'h07;
                        "b":     esc = 8'h08;
                        "t":     esc = 8'h09;
                        "n":     esc = 8'h0A;
                        "v":     esc = 8'h0B;
                        "f":     esc = 8'h0C;
                        "r":     esc = 8'h0D;
                        default: esc = b;
                    endcase
                    emit_byte(esc);
                    parse_st = MODE_NORMAL;
                end
            end
            MODE_AFTER_X:
            begin
                hv = hex_val(b);
                if (hv >= 0)
                begin
                    digit_acc = hv;
                    parse_st  = MODE_HEX;
                end
                else
                begin
                    err_code = STATUS_BAD_HEX;
                    parse_st = MODE_DEAD;
                end
            end
            MODE_HEX, MODE_OCT:
            begin
                if (parse_st == MODE_HEX)
                    hv = hex_val(b);
                else
                    hv = (b >= "0" && b <= "7") ? int'(b - "0") : -1;
                if (hv >= 0)
                begin
                    digit_acc = digit_acc * ((parse_st == MODE_HEX) ? 16 : 8) + hv;
                    if (digit_acc >= 256)
                    begin
                        digit_acc = 256;
                        err_code  = (parse_st == MODE_HEX) ? STATUS_HEX_RANGE : STATUS_OCT_RANGE;
                        parse_st  = MODE_DEAD;
                    end
                end
                else
                begin
                    emit_byte(digit_acc[7:0]);
                    digit_acc = 0;
                    parse_st  = MODE_NORMAL;
                    plain_byte(b);
                end
            end
            default: plain_byte(b);
        endcase

        if (last)
        begin
            code = STATUS_OK;
            if (parse_st == MODE_DEAD)
                code = err_code;
            else if (parse_st == MODE_AFTER_BS)
                code = STATUS_END_AFTER_BS;
            else if (parse_st == MODE_AFTER_X)
                code = STATUS_BAD_HEX;
            else if (parse_st == MODE_HEX || parse_st == MODE_OCT)
                emit_byte(digit_acc[7:0]);
            st = '{8'h00, 1'b1, code, lines, 1'b0};
            byte_results.push_back(st);
            parse_st  = MODE_NORMAL;
            digit_acc = 0;
            err_code  = STATUS_OK;
            lines     = 16'd0;
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].run_end = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input result_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, last);
        if (typed)
            expected_out.push_back(want);
        else
            foreach (byte_results[i])
                expected_out.push_back(byte_results[i]);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        return 8'((($urandom_range(0, 1) == 1) ? "a" : "A") + v - 10);
    endfunction

    // one text of random escape tokens, mostly well formed
    task automatic build_text();
        int         n_tok;
        int         n_dig;
        logic [7:0] c;
        text_buf.delete();
        n_tok = $urandom_range(1, 6);
        repeat (n_tok)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    c = 8'($urandom_range(32, 126));
                    text_buf.push_back((c == CHAR_BACKSLASH) ? 8'("A") : c);
                end
                1: text_buf.push_back(CHAR_NEWLINE);
                2: text_buf.push_back(8'($urandom_range(0, 255)));
                3:
                begin
                    text_buf.push_back(CHAR_BACKSLASH);
                    text_buf.push_back(esc_set[$urandom_range(0, 6)]);
                end
                4, 5:
                begin
                    text_buf.push_back(CHAR_BACKSLASH);
                    text_buf.push_back(CHAR_X);
                    n_dig = $urandom_range(1, 3);
                    repeat (n_dig) text_buf.push_back(rand_hex_char());
                end
                6:
                begin
                    text_buf.push_back(CHAR_BACKSLASH);
                    n_dig = $urandom_range(1, 4);
                    repeat (n_dig) text_buf.push_back(8'("0" + $urandom_range(0, 7)));
                end
                7:
                begin
                    text_buf.push_back(CHAR_BACKSLASH);
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    text_buf.push_back(CHAR_BACKSLASH);
                    text_buf.push_back(CHAR_NEWLINE);
                end
                default:
                begin
                    // broken escapes: bare backslash or \x with any byte
                    text_buf.push_back(CHAR_BACKSLASH);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        text_buf.push_back(CHAR_X);
                        text_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
            endcase
        end
    endtask

    function automatic void check_result();
        result_t want;
        if (expected_out.size() == 0)
        begin
            $error("unexpected result: tdata %08h tuser %0b tlast %0b",
                   m_tdata, m_tuser, m_tlast);
            mismatches++;
            return;
        end
        want = expected_out.pop_front();
        if (m_tdata[7:0] !== want.out_byte)
        begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata[7:0]);
            mismatches++;
        end
        if (m_tuser !== want.is_status)
        begin
            $error("is_status: expected %0b, got %0b", want.is_status, m_tuser);
            mismatches++;
        end
        if (m_tdata[10:8] !== want.status_code)
        begin
            $error("status_code: expected %0d, got %0d", want.status_code, m_tdata[10:8]);
            mismatches++;
        end
        if (m_tdata[26:11] !== want.line_offset)
        begin
            $error("line_offset: expected %0d, got %0d", want.line_offset, m_tdata[26:11]);
            mismatches++;
        end
        if (m_tlast !== want.run_end)
        begin
            $error("run_end: expected %0b, got %0b", want.run_end, m_tlast);
            mismatches++;
        end
    endfunction

    // result side: check each transaction, then pick tready for the next cycle
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_result();
                results_taken++;
                if (results_taken == 30)
                    long_hold = 60;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                m_tready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int random_bytes;
        int texts;
        random_bytes = 0;
        texts        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        while (random_bytes < 70)
        begin
            if (texts == 5)
                drain_results();
            build_text();
            foreach (text_buf[i])
                send_byte(text_buf[i], (i == text_buf.size() - 1), 1'b0, '0);
            random_bytes += text_buf.size();
            texts++;
        end

        // no idling from here
        idle_on = 1'b0;
        while (random_bytes < 85)
        begin
            build_text();
            foreach (text_buf[i])
                send_byte(text_buf[i], (i == text_buf.size() - 1), 1'b0, '0);
            random_bytes += text_buf.size();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("tb_c_escape_sequence_decoder: clean");
        else
            $display("tb_c_escape_sequence_decoder: errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ced_pkg.sv
hw/rtl/ced_step.sv
hw/rtl/c_escape_sequence_decoder.sv
sim/tb_c_escape_sequence_decoder.sv
